// File: rtl/mkts_pkg.sv
`default_nettype none
package mkts_pkg;
   localparam int CAPACITY = 64;
   localparam int MAX_KEYS = 3;
   localparam int KEY_W = 64;
   localparam int ROW_W = 32;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   localparam logic [1:0] REG_KEYS  = 2'd0;
   localparam logic [1:0] REG_DESC  = 2'd1;
   localparam logic [1:0] REG_SIGN  = 2'd2;
   localparam logic [1:0] REG_LIMIT = 2'd3;

   localparam logic KIND_OFFER = 1'b0;
   localparam logic KIND_EMIT  = 1'b1;

   typedef struct packed {
      logic             kind;
      logic [31:0]      row_id;
      logic [KEY_W-1:0] key_a;
      logic [KEY_W-1:0] key_b;
      logic [KEY_W-1:0] key_c;
   } req_type;

   typedef struct packed {
      logic [31:0] out_row;
      logic        is_last;
      logic        none_kept;
   } rsp_type;

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [KEY_W-1:0] key_a;
      logic [KEY_W-1:0] key_b;
      logic [KEY_W-1:0] key_c;
   } entry_type;

   // compare settings shared by all cells
   typedef struct packed {
      logic [1:0] nkeys;
      logic [2:0] desc;
      logic [2:0] sgn;
   } cmp_cfg_type;

   // one key: new strictly before, or strictly after
   function automatic logic [1:0] key_cmp(input logic [KEY_W-1:0] a_raw,
                                          input logic [KEY_W-1:0] b_raw,
                                          input logic sgn, input logic desc);
      logic [KEY_W-1:0] a;
      logic [KEY_W-1:0] b;
      logic lt;
      logic gt;
      a = a_raw ^ {sgn, {(KEY_W-1){1'b0}}};
      b = b_raw ^ {sgn, {(KEY_W-1){1'b0}}};
      lt = desc ? (a > b) : (a < b);
      gt = desc ? (a < b) : (a > b);
      return {lt, gt};
   endfunction

   function automatic logic comes_before(input entry_type n, input entry_type e,
                                         input cmp_cfg_type c);
      logic [1:0] r0;
      logic [1:0] r1;
      logic [1:0] r2;
      r0 = key_cmp(n.key_a, e.key_a, c.sgn[0], c.desc[0]);
      r1 = key_cmp(n.key_b, e.key_b, c.sgn[1], c.desc[1]);
      r2 = key_cmp(n.key_c, e.key_c, c.sgn[2], c.desc[2]);
      if (r0 != 2'b00 || c.nkeys == 2'd1) return r0[1];
      if (r1 != 2'b00 || c.nkeys == 2'd2) return r1[1];
      return r2[1];
   endfunction
endpackage
`default_nettype wire

// File: rtl/mkts_cell.sv
`default_nettype none
// One slot of the sorted chain. Slot i holds the i-th kept row.
module mkts_cell (
   input  wire logic                 clock,
   input  wire logic                 insert,      // offer broadcast this cycle
   input  wire logic                 shift_out,   // emit: take neighbor's entry
   input  wire mkts_pkg::cmp_cfg_type cfg,
   input  wire mkts_pkg::entry_type  new_entry,
   input  wire logic                 occ,         // this slot is below count
   input  wire logic                 prev_before, // new row goes at or before prev slot
   input  wire mkts_pkg::entry_type  prev_entry,
   input  wire mkts_pkg::entry_type  next_entry,
   output logic                      ahead,
   output mkts_pkg::entry_type       entry
);
   mkts_pkg::entry_type entry_ff, entry_in;

   always_comb begin
      ahead = !occ || mkts_pkg::comes_before(new_entry, entry_ff, cfg);
      entry_in = entry_ff;
      if (shift_out) begin
         entry_in = next_entry;
      end else if (insert && ahead) begin
         entry_in = prev_before ? prev_entry : new_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
endmodule
`default_nettype wire

// File: rtl/multi_key_top_k_select_unit.sv
`default_nettype none
// Streaming top-k selector over up to three 64-bit sort keys. Kept rows sit
// in a chain of compare cells, one per slot, in sort order. An offered row
// is compared in all cells in parallel; the req side accepts an offer every
// cycle while no emit runs and the output register is free. An emit of an
// empty store sends one none_kept result. An emit of kept rows sends the kept
// row ids one per cycle from slot 0 as the chain shifts toward it, while the
// output register is free; req_ready stays low until the last one is sent.
// Results pass through a one-entry output register. Configure only while idle.
module multi_key_top_k_select_unit (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire mkts_pkg::req_type  req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output mkts_pkg::rsp_type       rsp_data,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [3:0]         paddr,
   input  wire logic [31:0]        pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);
   localparam int N = mkts_pkg::CAPACITY;
   localparam int CW = mkts_pkg::CNT_W;

   logic [1:0] keys_ff;
   logic [2:0] desc_ff, sgn_ff;
   logic [6:0] limit_ff;
   logic [CW-1:0] count_ff, count_in;
   logic emitting_ff, emitting_in;
   logic rsp_valid_ff, rsp_valid_in;
   mkts_pkg::rsp_type rsp_ff, rsp_in;

   mkts_pkg::cmp_cfg_type cfg;
   mkts_pkg::entry_type new_entry;
   mkts_pkg::entry_type ent [N];
   logic [N-1:0] ahead;
   logic [CW-1:0] lim;
   logic [CW-1:0] cnt_trunc;
   logic insert, shift_out, emit_start, out_free, wr;

   assign pready = 1'b1;
   assign wr = psel && penable && pwrite;

   always_comb begin
      unique case (paddr[3:2])
         mkts_pkg::REG_KEYS:  prdata = {30'd0, keys_ff};
         mkts_pkg::REG_DESC:  prdata = {29'd0, desc_ff};
         mkts_pkg::REG_SIGN:  prdata = {29'd0, sgn_ff};
         mkts_pkg::REG_LIMIT: prdata = {25'd0, limit_ff};
         default:             prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keys_ff <= 2'd1;
         desc_ff <= 3'd0;
         sgn_ff <= 3'd0;
         limit_ff <= 7'd64;
      end else if (wr && paddr[1:0] == 2'b00) begin
         unique case (paddr[3:2])
            mkts_pkg::REG_KEYS:  keys_ff <= pwdata[1:0];
            mkts_pkg::REG_DESC:  desc_ff <= pwdata[2:0];
            mkts_pkg::REG_SIGN:  sgn_ff <= pwdata[2:0];
            mkts_pkg::REG_LIMIT: limit_ff <= pwdata[6:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.nkeys = (keys_ff == 2'd0) ? 2'd1 : keys_ff;
      cfg.desc = desc_ff;
      cfg.sgn = sgn_ff;
      lim = (32'(limit_ff) > 32'(N)) ? CW'(N) : CW'(limit_ff);
      cnt_trunc = (count_ff > lim) ? lim : count_ff;
      new_entry.row = req_data.row_id;
      new_entry.key_a = req_data.key_a;
      new_entry.key_b = req_data.key_b;
      new_entry.key_c = req_data.key_c;
   end

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = !emitting_ff && out_free;
   assign insert = req_valid && req_ready && req_data.kind == mkts_pkg::KIND_OFFER;
   assign emit_start = req_valid && req_ready && req_data.kind == mkts_pkg::KIND_EMIT;
   assign shift_out = emitting_ff && out_free;

   genvar g;
   generate
      for (g = 0; g < N; g++) begin : g_cell
         mkts_pkg::entry_type prev_e, next_e;
         logic prev_b, occ;
         if (g == 0) begin : g_first
            assign prev_e = new_entry;
            assign prev_b = 1'b0;
         end else begin : g_mid
            assign prev_e = ent[g-1];
            assign prev_b = ahead[g-1];
         end
         if (g == N - 1) begin : g_last
            assign next_e = ent[g];
         end else begin : g_nlast
            assign next_e = ent[g+1];
         end
         assign occ = CW'(g) < cnt_trunc;
         mkts_cell u_cell (
            .clock(clock), .insert(insert && CW'(g) < lim), .shift_out(shift_out),
            .cfg(cfg), .new_entry(new_entry), .occ(occ), .prev_before(prev_b),
            .prev_entry(prev_e), .next_entry(next_e), .ahead(ahead[g]),
            .entry(ent[g])
         );
      end
   endgenerate

   always_comb begin
      count_in = count_ff;
      emitting_in = emitting_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in = rsp_ff;
      if (insert) begin
         // slot at or past the limit means the row is dropped
         if (cnt_trunc < lim) begin
            count_in = cnt_trunc + CW'(1);
         end else begin
            count_in = cnt_trunc;
         end
         if (lim == '0) count_in = '0;
      end else if (emit_start) begin
         if (count_ff == '0) begin
            rsp_valid_in = 1'b1;
            rsp_in = '{out_row: 32'd0, is_last: 1'b1, none_kept: 1'b1};
         end else begin
            emitting_in = 1'b1;
         end
      end else if (shift_out) begin
         rsp_valid_in = 1'b1;
         rsp_in = '{out_row: ent[0].row, is_last: count_ff == CW'(1), none_kept: 1'b0};
         count_in = count_ff - CW'(1);
         if (count_ff == CW'(1)) emitting_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         emitting_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         emitting_ff <= emitting_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

`ifndef NO_ASSERTIONS
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(N)) else $error("count above capacity");
   a_no_accept_emit: assert property (@(posedge clock) disable iff (reset)
      emitting_ff |-> !req_ready) else $error("accept during emit");
   a_emit_end: assert property (@(posedge clock) disable iff (reset)
      (shift_out && count_ff == CW'(1)) |=> !emitting_ff && rsp_data.is_last)
      else $error("emit run did not end");
   a_drain: assert property (@(posedge clock) disable iff (reset)
      shift_out |=> count_ff == $past(count_ff) - CW'(1)) else $error("drain count");
`endif
endmodule
`default_nettype wire

// File: tb/tb_multi_key_top_k_select_unit.sv
`timescale 1ns / 1ps
`default_nettype none

class topk_scoreboard;
   localparam int CAP = mkts_pkg::CAPACITY;

   // live copy of the configuration
   logic [1:0] nkeys_reg;
   logic [2:0] desc_reg;
   logic [2:0] sign_reg;
   logic [6:0] limit_reg;

   logic [31:0] rows[CAP];
   logic [63:0] keys[3][CAP];
   int unsigned count;

   mkts_pkg::rsp_type pending_rows[$];
   int errors;
   int received;

   function new();
      nkeys_reg = 2'd1;
      desc_reg = 3'd0;
      sign_reg = 3'd0;
      limit_reg = 7'd64;
      count = 0;
      errors = 0;
      received = 0;
   endfunction

   function void set_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
         mkts_pkg::REG_KEYS:  nkeys_reg = value[1:0];
         mkts_pkg::REG_DESC:  desc_reg = value[2:0];
         mkts_pkg::REG_SIGN:  sign_reg = value[2:0];
         mkts_pkg::REG_LIMIT: limit_reg = value[6:0];
         default: ;
      endcase
   endfunction

   // true when the new keys sort strictly ahead of slot idx
   function bit ahead_of(logic [63:0] nk[3], int idx);
      int n;
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] t;
      n = (nkeys_reg == 2'd0) ? 1 : nkeys_reg;
      for (int k = 0; k < n; k++) begin
         a = nk[k];
         b = keys[k][idx];
         if (sign_reg[k]) begin
            a[63] = ~a[63];
            b[63] = ~b[63];
         end
         if (desc_reg[k]) begin
            t = a; a = b; b = t;
         end
         if (a < b) return 1;
         if (a > b) return 0;
      end
      return 0;
   endfunction

   function void note_item(mkts_pkg::req_type r);
      int unsigned lim;
      int unsigned pos;
      int unsigned newc;
      logic [63:0] nk[3];
      mkts_pkg::rsp_type e;
      if (r.kind == mkts_pkg::KIND_OFFER) begin
         lim = (limit_reg > CAP) ? CAP : limit_reg;
         nk[0] = r.key_a;
         nk[1] = r.key_b;
         nk[2] = r.key_c;
         if (count > lim) count = lim;
         pos = 0;
         while (pos < count && !ahead_of(nk, pos)) pos++;
         if (pos >= lim) return;
         newc = (count + 1 > lim) ? lim : count + 1;
         for (int i = newc - 1; i > int'(pos); i--) begin
            rows[i] = rows[i-1];
            for (int k = 0; k < 3; k++) keys[k][i] = keys[k][i-1];
         end
         rows[pos] = r.row_id;
         for (int k = 0; k < 3; k++) keys[k][pos] = nk[k];
         count = newc;
      end else if (count == 0) begin
         e.out_row = '0;
         e.is_last = 1'b1;
         e.none_kept = 1'b1;
         pending_rows.push_back(e);
      end else begin
         for (int i = 0; i < int'(count); i++) begin
            e.out_row = rows[i];
            e.is_last = (i + 1 == int'(count));
            e.none_kept = 1'b0;
            pending_rows.push_back(e);
         end
         count = 0;
      end
   endfunction

   function void report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("MISMATCH result %0d %s: got %h want %h", received, what, got, want);
   endfunction

   function void check_result(mkts_pkg::rsp_type got);
      mkts_pkg::rsp_type want;
      received++;
      if (pending_rows.size() == 0) begin
         report("unexpected result", got.out_row, 32'd0);
         return;
      end
      want = pending_rows.pop_front();
      if (got.out_row !== want.out_row) report("out_row", got.out_row, want.out_row);
      if (got.is_last !== want.is_last)
         report("is_last", 32'(got.is_last), 32'(want.is_last));
      if (got.none_kept !== want.none_kept)
         report("none_kept", 32'(got.none_kept), 32'(want.none_kept));
   endfunction
endclass

module tb_multi_key_top_k_select_unit;
   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   mkts_pkg::req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   mkts_pkg::rsp_type rsp_data;
   logic psel;
   logic penable;
   logic pwrite;
   logic [3:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic pready;

   topk_scoreboard board;
   int send_idle_pct;
   int recv_idle_pct;
   logic [63:0] key_pool[8];

   multi_key_top_k_select_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("Mismatches found");
      $finish;
   end

   // receiver: stall at random, check every accepted result
   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_result(rsp_data);
   end

   task automatic csr_write(logic [1:0] idx, logic [31:0] value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      board.set_reg(idx, value);
   endtask

   // returns at the accepting edge; the next call replaces or drops the item, drain drops valid
   task automatic send_item(mkts_pkg::req_type r);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_item(r);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.pending_rows.size() != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   function automatic logic [63:0] pick_key();
      case ($urandom_range(3))
         0: return {$urandom, $urandom};
         1: return key_pool[$urandom_range(7)];
         2: return 64'($urandom_range(4));
         default: return {$urandom, $urandom} ^ (64'd1 << $urandom_range(63));
      endcase
   endfunction

   task automatic offer(logic [31:0] id, logic [63:0] a, logic [63:0] b, logic [63:0] c);
      mkts_pkg::req_type r;
      r.kind = mkts_pkg::KIND_OFFER;
      r.row_id = id;
      r.key_a = a;
      r.key_b = b;
      r.key_c = c;
      send_item(r);
   endtask

   task automatic emit();
      mkts_pkg::req_type r;
      r.kind = mkts_pkg::KIND_EMIT;
      r.row_id = {$urandom};
      r.key_a = {$urandom, $urandom};
      r.key_b = {$urandom, $urandom};
      r.key_c = {$urandom, $urandom};
      send_item(r);
   endtask

   task automatic random_phase(int n_items);
      int burst;
      for (int i = 0; i < n_items; i += burst + 1) begin
         burst = $urandom_range(12);
         if ($urandom_range(15) == 0) burst = $urandom_range(70);
         for (int j = 0; j < burst; j++)
            offer($urandom, pick_key(), pick_key(), pick_key());
         emit();
      end
   endtask

   initial begin
      board = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      send_idle_pct = 7;
      recv_idle_pct = 47;
      key_pool = '{64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                   64'h7FFF_FFFF_FFFF_FFFF, 64'd1, 64'd2, 64'hFFFF_FFFF_FFFF_FFFE,
                   64'h8000_0000_0000_0001};
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty emit, extremes, ties, reset settings
      emit();
      offer(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, '1, '1);
      offer(32'd0, 64'd0, 64'd0, 64'd0);
      offer(32'd5, 64'h8000_0000_0000_0000, 64'd3, 64'd3);
      offer(32'd6, 64'd0, 64'd9, 64'd9);
      emit();
      emit();
      drain();
      csr_write(mkts_pkg::REG_KEYS, 32'd3);
      csr_write(mkts_pkg::REG_DESC, 32'd5);
      csr_write(mkts_pkg::REG_SIGN, 32'd3);
      csr_write(mkts_pkg::REG_LIMIT, 32'd2);
      offer(32'd10, 64'd1, 64'd1, 64'd1);
      offer(32'd11, 64'd1, 64'd1, 64'd2);
      offer(32'd12, 64'd1, 64'h8000_0000_0000_0000, 64'd0);
      offer(32'd13, 64'd1, 64'd1, 64'd2);
      emit();
      drain();
      csr_write(mkts_pkg::REG_LIMIT, 32'd0);
      offer(32'd20, 64'd7, 64'd7, 64'd7);
      emit();
      drain();
      csr_write(mkts_pkg::REG_LIMIT, 32'd127);
      csr_write(mkts_pkg::REG_KEYS, 32'd0);
      csr_write(mkts_pkg::REG_DESC, 32'hFFFF_FFFA);
      csr_write(mkts_pkg::REG_SIGN, 32'hFFFF_FFFC);
      for (int i = 0; i < 5; i++) offer(30 + i, pick_key(), pick_key(), pick_key());
      drain();
      // lower the limit while rows are kept
      csr_write(mkts_pkg::REG_LIMIT, 32'd3);
      emit();
      for (int i = 0; i < 4; i++) offer(40 + i, pick_key(), pick_key(), pick_key());
      drain();
      csr_write(mkts_pkg::REG_LIMIT, 32'd2);
      offer(50, pick_key(), pick_key(), pick_key());
      emit();
      drain();

      for (int phase = 0; phase < 3; phase++) begin
         if (phase == 1) begin
            send_idle_pct = 47;
            recv_idle_pct = 7;
         end else if (phase == 2) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         csr_write(mkts_pkg::REG_KEYS, $urandom_range(3));
         csr_write(mkts_pkg::REG_DESC, $urandom);
         csr_write(mkts_pkg::REG_SIGN, $urandom);
         csr_write(mkts_pkg::REG_LIMIT, (phase == 2) ? 32'd64 : $urandom_range(1, 20));
         random_phase(100);
         drain();
      end

      if (board.errors == 0 && board.pending_rows.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule

`default_nettype wire
